[hw/rtl/ivwm_pkg.sv]
// ----------------------------------------------------------------------------
// ivwm_pkg
// Types, constants and command/status bundles shared by the inverse-variance
// weighted mean block.
// ----------------------------------------------------------------------------
package ivwm_pkg;

    localparam int FRACTION_BITS = 16;

    // Weight is floor(2^(3*FRACTION_BITS) / sigma^2)
    localparam int RECIP_EXP   = 3 * FRACTION_BITS;
    localparam int RECIP_STEPS = RECIP_EXP + 1;
    localparam int MEAN_STEPS  = 64;
    localparam int MAX_STEPS   = (RECIP_STEPS > MEAN_STEPS) ? RECIP_STEPS : MEAN_STEPS;
    localparam int STEP_W      = $clog2(MAX_STEPS + 1);

    typedef logic [1:0] status_code_t;

    localparam status_code_t STATUS_OK          = 2'd0;
    localparam status_code_t STATUS_SIGMA       = 2'd1;
    localparam status_code_t STATUS_OVERFLOW    = 2'd2;
    localparam status_code_t STATUS_ZERO_WEIGHT = 2'd3;

    localparam int FLAG_SIGMA    = 0;
    localparam int FLAG_OVERFLOW = 1;

    typedef struct packed {
        logic signed [31:0] value;
        logic        [31:0] sigma;
        logic               last;
    } in_t;

    typedef struct packed {
        logic signed [31:0] mean;
        status_code_t       status;
        logic        [15:0] point_count;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQUARE,
        ST_RECIP_GO,
        ST_RECIP_WAIT,
        ST_PRODUCT,
        ST_ACCUM,
        ST_FINAL,
        ST_MEAN_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic reject;
        logic square;
        logic recip_go;
        logic take_weight;
        logic product;
        logic accum;
        logic mean_go;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic reject;
        logic last;
        logic div_done;
        logic wsum_zero;
        logic out_busy;
    } stat_t;

endpackage

[hw/rtl/inverse_variance_weighted_mean.sv]
// ----------------------------------------------------------------------------
// inverse_variance_weighted_mean
// Inverse-variance weighted mean over a stream of Q16.16 points.
//
// Input channel (in_valid / in_stall / in_data): one point per beat, carrying
// value, sigma and last. Output channel (out_valid / out_stall / out_data):
// one result beat per set, sent after the point marked last.
// cfg_we / cfg_wdata write the sigma threshold; reset value is 1.
// A point with sigma at or below the threshold is skipped. An accepted
// point is paced by the bit-serial reciprocal (49 steps for 16 fraction
// bits). The last point adds the 64-step mean division (skipped when the
// weight sum is zero) plus the emit.
// Reset clears the sums, count, flags and output valid, and sets the
// threshold to 1. The result sits in an output register; while it is
// stalled the block keeps taking points and only holds when a further
// result is ready to go out.
// ----------------------------------------------------------------------------
module inverse_variance_weighted_mean
    import ivwm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    cmd_t   cmd;
    stat_t  dp_stat;
    state_t state;

    ivwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (dp_stat),
        .cmd      (cmd),
        .state    (state)
    );

    ivwm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (dp_stat),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef SYNTH
    // a new beat is never taken straight after another
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken on consecutive cycles");

    // a result must never overwrite one still held by the receiver
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid && out_stall))
        else $error("result emitted over a stalled beat");

    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> dp_stat.wsum_zero)
        else $error("weight sum not cleared after emit");

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.emit))
        else $error("output valid without emit");

    a_take_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state == ST_IDLE))
        else $error("point loaded outside idle");
`endif

endmodule

[hw/rtl/ivwm_div.sv]
// ----------------------------------------------------------------------------
// ivwm_div
// Restoring divider, one quotient bit per cycle, 64-bit operands. The step
// count is loaded with the operands; the dividend is shifted in MSB first.
// ----------------------------------------------------------------------------
module ivwm_div
    import ivwm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [63:0]       num,
    input  logic [63:0]       den,
    input  logic [STEP_W-1:0] steps,
    output logic              done,
    output logic [63:0]       quotient,
    output logic              overflow
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg,  cnt_next;
    logic [63:0]       num_reg;
    logic [63:0]       den_reg;
    logic [63:0]       rem_reg;
    logic [63:0]       quo_reg;
    logic              ovf_reg;

    logic [64:0] rem_shift;
    logic [64:0] diff;
    logic        ge;

    assign rem_shift = {rem_reg, num_reg[63]};
    assign diff      = rem_shift - {1'b0, den_reg};
    assign ge        = ~diff[64];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[63:0] : rem_shift[63:0];
            quo_reg <= {quo_reg[62:0], ge};
            // a set bit leaving the top means the quotient no longer fits
            ovf_reg <= ovf_reg | quo_reg[63];
            num_reg <= {num_reg[62:0], 1'b0};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign overflow = ovf_reg;

endmodule

[hw/rtl/ivwm_dp.sv]
// ----------------------------------------------------------------------------
// ivwm_dp
// Datapath: item and threshold registers, shared 32x32 multiplier, the
// divider, saturating accumulators and the output register.
// ----------------------------------------------------------------------------
module ivwm_dp
    import ivwm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  in_t         in_data,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data
);

    logic [31:0] thr_reg;
    in_t         item_reg;
    logic [63:0] mul_reg;
    logic [31:0] w_reg;
    logic [63:0] wsum_reg,  wsum_next;
    logic [63:0] wvsum_reg, wvsum_next;
    logic [15:0] count_reg;
    logic [1:0]  flags_reg, flags_next;
    logic        out_valid_reg, out_valid_next;
    out_t        out_reg;
    out_t        result;

    logic        x_neg;
    logic [31:0] x_mag;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_full;

    logic        div_start;
    logic [63:0] div_num, div_den;
    logic [STEP_W-1:0] div_steps;
    logic        div_done;
    logic [63:0] quo;
    logic        div_ovf;

    logic [64:0] wsum_add;
    logic [63:0] sp;
    logic [64:0] wv_add;
    logic        wv_ovf;
    logic        wv_neg;
    logic [63:0] wv_mag;

    assign x_neg = item_reg.value[31];
    // most negative value maps onto itself, which is its correct magnitude
    assign x_mag = x_neg ? (~item_reg.value + 32'd1) : item_reg.value;

    assign mul_a    = cmd.square ? item_reg.sigma : w_reg;
    assign mul_b    = cmd.square ? item_reg.sigma : x_mag;
    assign mul_full = 64'(mul_a) * 64'(mul_b);

    assign wv_neg = wvsum_reg[63];
    assign wv_mag = wv_neg ? (64'd0 - wvsum_reg) : wvsum_reg;

    assign div_start = cmd.recip_go | cmd.mean_go;
    assign div_num   = cmd.recip_go ? {1'b1, 63'd0} : wv_mag;
    assign div_den   = cmd.recip_go ? mul_reg : wsum_reg;
    assign div_steps = cmd.recip_go ? STEP_W'(RECIP_STEPS) : STEP_W'(MEAN_STEPS);

    ivwm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (quo),
        .overflow (div_ovf)
    );

    assign wsum_add = {1'b0, wsum_reg} + {33'd0, w_reg};
    assign sp       = x_neg ? (64'd0 - mul_reg) : mul_reg;
    assign wv_add   = {wvsum_reg[63], wvsum_reg} + {sp[63], sp};
    assign wv_ovf   = wv_add[64] ^ wv_add[63];

    always_comb
    begin
        result.point_count = count_reg;
        result.mean        = '0;
        if (wsum_reg == 64'd0)
        begin
            result.status = STATUS_ZERO_WEIGHT;
        end
        else
        begin
            if (wv_neg)
            begin
                if ((quo[63:32] != 32'd0) || (quo[31] && (quo[30:0] != 31'd0)))
                    result.mean = 32'sh8000_0000;
                else
                    result.mean = 32'd0 - quo[31:0];
            end
            else
            begin
                if (quo[63:31] != 33'd0)
                    result.mean = 32'sh7FFF_FFFF;
                else
                    result.mean = quo[31:0];
            end
            if (flags_reg[FLAG_OVERFLOW])
                result.status = STATUS_OVERFLOW;
            else if (flags_reg[FLAG_SIGMA])
                result.status = STATUS_SIGMA;
            else
                result.status = STATUS_OK;
        end
    end

    always_comb
    begin
        wsum_next  = wsum_reg;
        wvsum_next = wvsum_reg;
        flags_next = flags_reg;
        if (cmd.reject)
            flags_next[FLAG_SIGMA] = 1'b1;
        if (cmd.accum)
        begin
            wsum_next = wsum_add[64] ? '1 : wsum_add[63:0];
            if (wv_ovf)
                wvsum_next = wv_add[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else
                wvsum_next = wv_add[63:0];
            if (wsum_add[64] || wv_ovf)
                flags_next[FLAG_OVERFLOW] = 1'b1;
        end
        if (cmd.emit)
        begin
            wsum_next  = '0;
            wvsum_next = '0;
            flags_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= 32'd1;
            wsum_reg      <= '0;
            wvsum_reg     <= '0;
            count_reg     <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                thr_reg <= cfg_wdata;
            wsum_reg      <= wsum_next;
            wvsum_reg     <= wvsum_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
            if (cmd.emit)
                count_reg <= '0;
            else if (cmd.accum && (count_reg != 16'hFFFF))
                count_reg <= count_reg + 16'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_data;
        if (cmd.square || cmd.product)
            mul_reg <= mul_full;
        if (cmd.take_weight)
            w_reg <= (div_ovf || (quo[63:32] != 32'd0)) ? '1 : quo[31:0];
        if (cmd.emit)
            out_reg <= result;
    end

    assign stat.reject    = (item_reg.sigma <= thr_reg);
    assign stat.last      = item_reg.last;
    assign stat.div_done  = div_done;
    assign stat.wsum_zero = (wsum_reg == 64'd0);
    assign stat.out_busy  = out_valid_reg & out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[hw/rtl/ivwm_ctrl.sv]
// ----------------------------------------------------------------------------
// ivwm_ctrl
// Sequencer: checks each point; accepted ones go on through square,
// reciprocal, product and accumulate; the last runs mean division and emit.
// ----------------------------------------------------------------------------
module ivwm_ctrl
    import ivwm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  stat_t  stat,
    output cmd_t   cmd,
    output state_t state
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_CHECK;
            ST_CHECK:
                if (stat.reject)
                    state_next = stat.last ? ST_FINAL : ST_IDLE;
                else
                    state_next = ST_SQUARE;
            ST_SQUARE:
                state_next = ST_RECIP_GO;
            ST_RECIP_GO:
                state_next = ST_RECIP_WAIT;
            ST_RECIP_WAIT:
                if (stat.div_done)
                    state_next = ST_PRODUCT;
            ST_PRODUCT:
                state_next = ST_ACCUM;
            ST_ACCUM:
                state_next = stat.last ? ST_FINAL : ST_IDLE;
            ST_FINAL:
                state_next = stat.wsum_zero ? ST_EMIT : ST_MEAN_WAIT;
            ST_MEAN_WAIT:
                if (stat.div_done)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (!stat.out_busy)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_CHECK:      cmd.reject      = stat.reject;
            ST_SQUARE:     cmd.square      = 1'b1;
            ST_RECIP_GO:   cmd.recip_go    = 1'b1;
            ST_RECIP_WAIT: cmd.take_weight = stat.div_done;
            ST_PRODUCT:    cmd.product     = 1'b1;
            ST_ACCUM:      cmd.accum       = 1'b1;
            ST_FINAL:      cmd.mean_go     = ~stat.wsum_zero;
            ST_MEAN_WAIT:  ;
            ST_EMIT:       cmd.emit        = ~stat.out_busy;
            default:       ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign state = state_reg;

endmodule
